// ----- sv/pfcs_pkg.sv -----
// Shared types and constants for the parallel flash command sequencer.
// Item structs, job descriptor, bus codes and command bytes. No dependencies.
package pfcs_pkg;

	localparam int FLASH_AW   = 19;
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = 2;

	// input opcodes
	localparam logic [2:0] OP_PROGRAM = 3'd0;
	localparam logic [2:0] OP_ERASE   = 3'd1;
	localparam logic [2:0] OP_READ_ID = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_RESET   = 3'd4;
	localparam logic [2:0] OP_RELOAD  = 3'd5;
	localparam logic [2:0] OP_REPLY   = 3'd6;
	localparam logic [2:0] OP_UNUSED  = 3'd7;

	// result kinds
	localparam logic [1:0] K_WRITE  = 2'd0;
	localparam logic [1:0] K_READ   = 2'd1;
	localparam logic [1:0] K_RELOAD = 2'd2;
	localparam logic [1:0] K_DONE   = 2'd3;

	// completion status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PROTECTED = 2'd1;
	localparam logic [1:0] ST_FAILED    = 2'd2;
	localparam logic [1:0] ST_BAD_ID    = 2'd3;

	// job types handed from front to back
	localparam logic [2:0] J_PROG    = 3'd0;
	localparam logic [2:0] J_SECTOR  = 3'd1;
	localparam logic [2:0] J_IDSTART = 3'd2;
	localparam logic [2:0] J_READ    = 3'd3;
	localparam logic [2:0] J_RESETW  = 3'd4;
	localparam logic [2:0] J_RELOAD  = 3'd5;
	localparam logic [2:0] J_DONE    = 3'd6;
	localparam logic [2:0] J_IDEND   = 3'd7;

	// sequencer phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_PROG  = 3'd1;
	localparam logic [2:0] PH_ERASE = 3'd2;
	localparam logic [2:0] PH_IDMAN = 3'd3;
	localparam logic [2:0] PH_IDDEV = 3'd4;
	localparam logic [2:0] PH_READ  = 3'd5;

	// JEDEC addresses and command bytes
	localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
	localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
	localparam logic [7:0]  D_UNLOCK1    = 8'hAA;
	localparam logic [7:0]  D_UNLOCK2    = 8'h55;
	localparam logic [7:0]  C_PROGRAM    = 8'hA0;
	localparam logic [7:0]  C_ERASE_SET  = 8'h80;
	localparam logic [7:0]  C_SECTOR     = 8'h30;
	localparam logic [7:0]  C_AUTOSEL    = 8'h90;
	localparam logic [7:0]  C_RESET      = 8'hF0;
	localparam logic [7:0]  RELOAD_USER  = 8'hC0;
	localparam logic [7:0]  RELOAD_DEF   = 8'h80;
	localparam logic [15:0] ID_A         = 16'h014F;
	localparam logic [15:0] ID_B         = 16'h20E3;

	typedef struct packed {
		logic [2:0]  op;
		logic        sector_user;
		logic        use_sram;
		logic [17:0] addr;
		logic [7:0]  wdata;
		logic [7:0]  rdata;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [FLASH_AW-1:0] flash_addr;
		logic [7:0]          bus_data;
		logic                to_sram;
		logic [1:0]          status;
		logic [15:0]         id_value;
		logic                last;
	} rsp_item_t;

	typedef struct packed {
		logic [2:0]          jtype;
		logic [FLASH_AW-1:0] addr;
		logic [FLASH_AW-1:0] u5555;
		logic [FLASH_AW-1:0] u2aaa;
		logic [7:0]          data;
		logic                sram;
		logic [1:0]          status;
		logic [15:0]         id;
	} job_t;

endpackage

// ----- sv/pfcs_front.sv -----
// Front end: accepts commands and poll replies, keeps the sequencer state,
// and emits one job descriptor per item that yields results. Uses pfcs_pkg.
module pfcs_front import pfcs_pkg::*; #(
	parameter int OFFSET_BITS        = 18,
	parameter int SECTORS_PER_REGION = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	input  logic      push,
	output logic      full,
	input  cmd_item_t cmd,
	input  logic      job_full,
	output logic      job_push,
	output job_t      job
);

	localparam int SIW         = (SECTORS_PER_REGION > 1) ? $clog2(SECTORS_PER_REGION) : 1;
	localparam int SECTOR_SIZE = (1 << OFFSET_BITS) / SECTORS_PER_REGION;

	function automatic logic [FLASH_AW-1:0] place(input logic [OFFSET_BITS-1:0] off,
	                                              input logic user);
		logic [OFFSET_BITS:0] w;
		w = {user, off};
		return FLASH_AW'(w);
	endfunction

	logic                wp_q;
	logic [2:0]          phase_q, phase_d;
	logic [SIW-1:0]      sidx_q, sidx_d;
	logic [FLASH_AW-1:0] target_q, target_d;
	logic                exp_dq7_q, exp_dq7_d;
	logic                dq5_q, dq5_d;
	logic [7:0]          idhi_q, idhi_d;
	logic                user_q, user_d;

	logic                accept;
	logic                job_req;
	logic                prot;
	logic                ok;
	logic [FLASH_AW-1:0] a_in;
	logic [FLASH_AW-1:0] a_next_sector;
	logic [SIW-1:0]      sidx_inc;
	logic [15:0]         id_full;
	logic                user_sel;

	assign cfg_ready = 1'b1;
	assign full      = job_full;
	assign accept    = push && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
		end else if (cfg_valid) begin
			wp_q <= cfg_data;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		sidx_d    = sidx_q;
		target_d  = target_q;
		exp_dq7_d = exp_dq7_q;
		dq5_d     = dq5_q;
		idhi_d    = idhi_q;
		user_d    = user_q;
		job_req   = 1'b0;
		job       = '0;

		prot          = !cmd.sector_user && wp_q;
		a_in          = place(OFFSET_BITS'(cmd.addr), cmd.sector_user);
		sidx_inc      = sidx_q + SIW'(1);
		a_next_sector = place(OFFSET_BITS'(SECTOR_SIZE * sidx_inc), user_q);
		id_full       = {idhi_q, cmd.rdata};
		ok            = (phase_q == PH_PROG) ? (cmd.rdata[7] == exp_dq7_q) : cmd.rdata[7];

		// unlock addresses follow the region of the item in hand: replies use
		// the stored region, commands their own
		user_sel  = (cmd.op == OP_REPLY) ? user_q : cmd.sector_user;
		job.u5555 = place(OFFSET_BITS'(ADDR_UNLOCK1), user_sel);
		job.u2aaa = place(OFFSET_BITS'(ADDR_UNLOCK2), user_sel);

		if (cmd.op == OP_REPLY) begin
			case (phase_q)
				PH_PROG, PH_ERASE: begin
					job_req = 1'b1;
					if (ok) begin
						if (phase_q == PH_ERASE &&
						    (32'(sidx_q) + 32'd1) < 32'(SECTORS_PER_REGION)) begin
							sidx_d    = sidx_inc;
							target_d  = a_next_sector;
							dq5_d     = 1'b0;
							job.jtype = J_SECTOR;
							job.addr  = a_next_sector;
						end else begin
							phase_d   = PH_IDLE;
							job.jtype = J_DONE;
							job.addr  = target_q;
							job.data  = cmd.rdata;
						end
					end else if (dq5_q) begin
						phase_d    = PH_IDLE;
						dq5_d      = 1'b0;
						job.jtype  = J_DONE;
						job.addr   = target_q;
						job.data   = cmd.rdata;
						job.status = ST_FAILED;
					end else begin
						// keep polling; DQ5 arms one last read
						dq5_d     = cmd.rdata[5];
						job.jtype = J_READ;
						job.addr  = target_q;
					end
				end
				PH_IDMAN: begin
					job_req   = 1'b1;
					idhi_d    = cmd.rdata;
					phase_d   = PH_IDDEV;
					target_d  = place(OFFSET_BITS'(1), user_q);
					job.jtype = J_READ;
					job.addr  = place(OFFSET_BITS'(1), user_q);
				end
				PH_IDDEV: begin
					job_req    = 1'b1;
					phase_d    = PH_IDLE;
					job.jtype  = J_IDEND;
					job.addr   = target_q;
					job.data   = cmd.rdata;
					job.id     = id_full;
					job.status = (id_full == ID_A || id_full == ID_B) ? ST_OK : ST_BAD_ID;
				end
				PH_READ: begin
					job_req   = 1'b1;
					phase_d   = PH_IDLE;
					job.jtype = J_DONE;
					job.addr  = target_q;
					job.data  = cmd.rdata;
				end
				default: begin
					job_req = 1'b0;
				end
			endcase
		end else if (cmd.op == OP_UNUSED) begin
			job_req = 1'b0;
		end else if (phase_q != PH_IDLE) begin
			job_req    = 1'b1;
			job.jtype  = J_DONE;
			job.status = ST_FAILED;
		end else begin
			job_req = 1'b1;
			user_d  = cmd.sector_user;
			case (cmd.op)
				OP_PROGRAM: begin
					job.addr = a_in;
					if (prot) begin
						job.jtype  = J_DONE;
						job.status = ST_PROTECTED;
					end else begin
						job.jtype = J_PROG;
						job.data  = cmd.wdata;
						target_d  = a_in;
						exp_dq7_d = cmd.wdata[7];
						dq5_d     = 1'b0;
						phase_d   = PH_PROG;
					end
				end
				OP_ERASE: begin
					job.addr = place('0, cmd.sector_user);
					if (prot) begin
						job.jtype  = J_DONE;
						job.status = ST_PROTECTED;
					end else begin
						job.jtype = J_SECTOR;
						sidx_d    = '0;
						target_d  = place('0, cmd.sector_user);
						dq5_d     = 1'b0;
						phase_d   = PH_ERASE;
					end
				end
				OP_READ_ID: begin
					job.jtype = J_IDSTART;
					job.addr  = place('0, cmd.sector_user);
					job.sram  = cmd.use_sram;
					target_d  = place('0, cmd.sector_user);
					phase_d   = PH_IDMAN;
				end
				OP_READ: begin
					job.jtype = J_READ;
					job.addr  = a_in;
					target_d  = a_in;
					phase_d   = PH_READ;
				end
				OP_RESET: begin
					job.jtype = J_RESETW;
				end
				default: begin
					job.jtype = J_RELOAD;
					job.data  = cmd.sector_user ? RELOAD_USER : RELOAD_DEF;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sidx_q    <= '0;
			target_q  <= '0;
			exp_dq7_q <= 1'b0;
			dq5_q     <= 1'b0;
			idhi_q    <= '0;
			user_q    <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			sidx_q    <= sidx_d;
			target_q  <= target_d;
			exp_dq7_q <= exp_dq7_d;
			dq5_q     <= dq5_d;
			idhi_q    <= idhi_d;
			user_q    <= user_d;
		end
	end

	// drop the push when the item is not taken
	assign job_push = job_req && accept;

endmodule

// ----- sv/pfcs_jobq.sv -----
// Small job queue between the front and back ends of the flash sequencer.
// Holds JOBQ_DEPTH job descriptors. Uses pfcs_pkg.
module pfcs_jobq import pfcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	output logic full,
	input  logic rd,
	output job_t rdata,
	output logic empty
);

	job_t               mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wptr_q;
	logic [JOBQ_AW-1:0] rptr_q;
	logic [JOBQ_AW:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = (cnt_q == (JOBQ_AW + 1)'(JOBQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + JOBQ_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + JOBQ_AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (JOBQ_AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (JOBQ_AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/pfcs_back.sv -----
// Back end: expands each job into its flash bus beats into a single output
// register, one beat per cycle while that register is empty or being popped. Uses pfcs_pkg.
module pfcs_back import pfcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_valid,
	output logic      job_pop,
	output rsp_item_t rsp,
	output logic      empty,
	input  logic      pop
);

	function automatic rsp_item_t mk(input logic [1:0] k, input logic [FLASH_AW-1:0] a,
	                                 input logic [7:0] d, input logic s,
	                                 input logic [1:0] st, input logic [15:0] id,
	                                 input logic l);
		rsp_item_t r;
		r.kind       = k;
		r.flash_addr = a;
		r.bus_data   = d;
		r.to_sram    = s;
		r.status     = st;
		r.id_value   = id;
		r.last       = l;
		return r;
	endfunction

	rsp_item_t           out_q;
	logic                out_valid_q;
	logic [2:0]          bcnt_q;
	rsp_item_t           beat;
	logic                fire;
	logic [FLASH_AW-1:0] unl_addr;
	logic [7:0]          unl_data;

	always_comb begin
		unl_addr = (bcnt_q == 3'd1) ? job.u2aaa : job.u5555;
		unl_data = (bcnt_q == 3'd0) ? D_UNLOCK1 : D_UNLOCK2;
		beat     = mk(K_WRITE, '0, '0, 1'b0, ST_OK, '0, 1'b1);
		case (job.jtype)
			J_PROG: begin
				case (bcnt_q)
					3'd0, 3'd1: beat = mk(K_WRITE, unl_addr, unl_data, 1'b0, ST_OK, '0, 1'b0);
					3'd2:    beat = mk(K_WRITE, job.u5555, C_PROGRAM, 1'b0, ST_OK, '0, 1'b0);
					3'd3:    beat = mk(K_WRITE, job.addr, job.data, 1'b0, ST_OK, '0, 1'b0);
					default: beat = mk(K_READ, job.addr, '0, 1'b0, ST_OK, '0, 1'b1);
				endcase
			end
			J_SECTOR: begin
				case (bcnt_q)
					3'd0, 3'd1: beat = mk(K_WRITE, unl_addr, unl_data, 1'b0, ST_OK, '0, 1'b0);
					3'd2:    beat = mk(K_WRITE, job.u5555, C_ERASE_SET, 1'b0, ST_OK, '0, 1'b0);
					3'd3:    beat = mk(K_WRITE, job.u5555, D_UNLOCK1, 1'b0, ST_OK, '0, 1'b0);
					3'd4:    beat = mk(K_WRITE, job.u2aaa, D_UNLOCK2, 1'b0, ST_OK, '0, 1'b0);
					3'd5:    beat = mk(K_WRITE, job.addr, C_SECTOR, 1'b0, ST_OK, '0, 1'b0);
					default: beat = mk(K_READ, job.addr, '0, 1'b0, ST_OK, '0, 1'b1);
				endcase
			end
			J_IDSTART: begin
				case (bcnt_q)
					3'd0, 3'd1: beat = mk(K_WRITE, unl_addr, unl_data, job.sram, ST_OK, '0, 1'b0);
					3'd2:    beat = mk(K_WRITE, job.u5555, C_AUTOSEL, job.sram, ST_OK, '0, 1'b0);
					default: beat = mk(K_READ, job.addr, '0, 1'b0, ST_OK, '0, 1'b1);
				endcase
			end
			J_READ: beat = mk(K_READ, job.addr, '0, 1'b0, ST_OK, '0, 1'b1);
			J_RESETW: begin
				if (bcnt_q == 3'd0) begin
					beat = mk(K_WRITE, '0, C_RESET, 1'b0, ST_OK, '0, 1'b0);
				end else begin
					beat = mk(K_DONE, '0, '0, 1'b0, ST_OK, '0, 1'b1);
				end
			end
			J_RELOAD: begin
				if (bcnt_q == 3'd0) begin
					beat = mk(K_RELOAD, '0, job.data, 1'b0, ST_OK, '0, 1'b0);
				end else begin
					beat = mk(K_DONE, '0, '0, 1'b0, ST_OK, '0, 1'b1);
				end
			end
			J_IDEND: begin
				if (bcnt_q == 3'd0) begin
					beat = mk(K_WRITE, '0, C_RESET, 1'b0, ST_OK, '0, 1'b0);
				end else begin
					beat = mk(K_DONE, job.addr, job.data, 1'b0, job.status, job.id, 1'b1);
				end
			end
			default: beat = mk(K_DONE, job.addr, job.data, 1'b0, job.status, job.id, 1'b1);
		endcase
	end

	assign fire    = job_valid && (!out_valid_q || pop);
	assign job_pop = fire && beat.last;
	assign rsp     = out_q;
	assign empty   = !out_valid_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bcnt_q      <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				bcnt_q      <= beat.last ? 3'd0 : bcnt_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/parallel_flash_command_sequencer_core.sv -----
// Top level: front end classifies items, a 4-deep job queue decouples it from
// the back end, which drives one bus beat per cycle while the output is not stalled. Uses pfcs_pkg.
// The first beat of an item reaches the result ports through the job queue and then the
// output register. Throughput: one item a cycle at the input while the queue has room;
// the back end sets the sustained rate by the beats each item needs, one to seven.
// Reset (arst_n low, asynchronous): idle phase, queue and output empty, protect off.
module parallel_flash_command_sequencer_core import pfcs_pkg::*; #(
	parameter int OFFSET_BITS        = 18,
	parameter int SECTORS_PER_REGION = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	// configuration: default region write protect
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	// command / poll reply queue side
	input  logic      push,
	output logic      full,
	input  cmd_item_t cmd,
	// result queue side
	output logic      empty,
	input  logic      pop,
	output rsp_item_t rsp
);

	job_t q_wdata;
	job_t q_rdata;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	// Front end: hold the sequencer state and turn each item that yields results into one job.
	pfcs_front #(
		.OFFSET_BITS        (OFFSET_BITS),
		.SECTORS_PER_REGION (SECTORS_PER_REGION)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.job_full  (q_full),
		.job_push  (q_push),
		.job       (q_wdata)
	);

	// Job queue: let the front take new items while the back still emits beats.
	pfcs_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back end: advance through the job's beats; drop the job after its last beat.
	pfcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_rdata),
		.job_valid (!q_empty),
		.job_pop   (q_pop),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
